>>> sv/triangle_area_and_bounds_core_macros.svh
// Assertion macros for the triangle area and bounds core.
// Used by tab_isqrt and the top level; no other dependencies.
`ifndef TRIANGLE_AREA_AND_BOUNDS_CORE_MACROS_SVH
`define TRIANGLE_AREA_AND_BOUNDS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TAB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("lbl");
`define TAB_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("lbl");
`else
`define TAB_ASSERT(lbl, clk, rstn, prop)
`define TAB_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

>>> sv/tab_pkg.sv
// Types and constants for the triangle area and bounds core.
// No dependencies.
`timescale 1ns / 1ps
package tab_pkg;
  localparam int CoordBits = 16;
  localparam int AreaBits = 2 * CoordBits + 1;
  localparam int RadBits = CoordBits + 1;
  localparam int EdgeBits = CoordBits + 1;
  localparam int CrossBits = 2 * EdgeBits + 1;
  localparam int MagBits = 2 * EdgeBits;
  localparam int SqBits = 2 * MagBits + 2;
  localparam int DistBits = CoordBits + 2;
  localparam int D2Bits = 2 * DistBits + 2;
  localparam int AreaRootBits = SqBits / 2;
  // lane 0: area square, lanes 1..3: vertex distance squares
  localparam int SqrtLanes = 4;

  typedef struct packed {
    logic [CoordBits-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic                 indices_valid;
    logic [15:0]          triangle_tag;
  } tab_req_t;

  typedef struct packed {
    logic [AreaBits-1:0]  area;
    logic [CoordBits-1:0] center_x, center_y, center_z;
    logic [RadBits-1:0]   radius;
    logic [15:0]          result_tag;
  } tab_res_t;

  typedef struct packed {
    logic                 vld;
    logic                 ok;
    logic [15:0]          tag;
  } tab_ctl_t;
endpackage

>>> sv/tab_isqrt.sv
// Pipelined floored integer square root, one result bit per stage, no multipliers.
// Depends on tab_pkg.
`timescale 1ns / 1ps
`include "triangle_area_and_bounds_core_macros.svh"
module tab_isqrt import tab_pkg::*; (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [SqrtLanes-1:0][SqBits-1:0]       val_i,
  input  tab_ctl_t                               ctl_i,
  output logic [SqrtLanes-1:0][AreaRootBits-1:0] root_o,
  output tab_ctl_t                               ctl_o
);
  localparam int RB = AreaRootBits;
  logic [RB-2:0][SqrtLanes-1:0][SqBits-1:0] rem_q;
  logic [RB-1:0][SqrtLanes-1:0][RB-1:0]     rt_q;
  tab_ctl_t [RB-1:0]                        ctl_q;

  for (genvar s = 0; s < RB; s++) begin : g_st
    localparam int B = RB - 1 - s;
    logic [SqrtLanes-1:0][SqBits-1:0] rem_in, rem_d;
    logic [SqrtLanes-1:0][RB-1:0]     rt_in, rt_d;
    tab_ctl_t                         ctl_in;

    if (s == 0) begin : g_head
      assign rem_in = val_i;
      assign rt_in = '0;
      assign ctl_in = ctl_i;
    end else begin : g_link
      assign rem_in = rem_q[s-1];
      assign rt_in = rt_q[s-1];
      assign ctl_in = ctl_q[s-1];
    end

    // rem holds x - root^2; trial is (root|bit)^2 - root^2
    always_comb begin
      for (int l = 0; l < SqrtLanes; l++) begin
        logic [SqBits-1:0] trial;
        trial = (SqBits'(rt_in[l]) << (B + 1)) | (SqBits'(1) << (2 * B));
        if (trial <= rem_in[l]) begin
          rem_d[l] = rem_in[l] - trial;
          rt_d[l] = rt_in[l] | (RB'(1) << B);
        end else begin
          rem_d[l] = rem_in[l];
          rt_d[l] = rt_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rt_q[s] <= rt_d;
    end

    if (s < RB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= rem_d;
      end
    end
  end

  assign root_o = rt_q[RB-1];
  assign ctl_o = ctl_q[RB-1];

  `TAB_ASSERT_NEXT(a_sq_vld, clk_i, rst_ni, ctl_i.vld, ctl_q[0].vld)
  `TAB_ASSERT_NEXT(a_sq_idle, clk_i, rst_ni, !ctl_i.vld, !ctl_q[0].vld)
  `TAB_ASSERT(a_sq_out, clk_i, rst_ni, ctl_o.vld == $past(ctl_q[RB-2].vld))
endmodule

>>> sv/tab_front.sv
// Front stages: edges, cross products, centroid, squared magnitudes.
// Depends on tab_pkg.
`timescale 1ns / 1ps
module tab_front import tab_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  tab_req_t                          req_i,
  output logic [SqBits-1:0]                 asq_o,
  output logic [2:0][D2Bits-1:0]            dsq_o,
  output logic signed [2:0][CoordBits-1:0]  ctr_o,
  output tab_ctl_t                          ctl_o
);
  typedef logic signed [CoordBits-1:0] crd_t;
  // stage 1: edges, sums
  logic signed [2:0][EdgeBits-1:0] e1_q, e2_q;
  logic signed [2:0][CoordBits-1:0] v_q [3];
  logic signed [2:0][CoordBits+1:0] sum_q;
  tab_ctl_t c1_q, c2_q, c3_q, c4_q;
  crd_t v [3][3];

  always_comb begin
    v[0][0] = req_i.a_x; v[0][1] = req_i.a_y; v[0][2] = req_i.a_z;
    v[1][0] = req_i.b_x; v[1][1] = req_i.b_y; v[1][2] = req_i.b_z;
    v[2][0] = req_i.c_x; v[2][1] = req_i.c_y; v[2][2] = req_i.c_z;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e1_q[k] <= EdgeBits'(v[1][k]) - EdgeBits'(v[0][k]);
      e2_q[k] <= EdgeBits'(v[2][k]) - EdgeBits'(v[0][k]);
      sum_q[k] <= (CoordBits+2)'(v[0][k]) + (CoordBits+2)'(v[1][k])
                  + (CoordBits+2)'(v[2][k]);
      for (int i = 0; i < 3; i++) v_q[i][k] <= v[i][k];
    end
  end

  // stage 2: cross products, centroid (round via reciprocal multiply)
  logic signed [2:0][CrossBits-1:0] cr_q;
  logic signed [2:0][CoordBits-1:0] ct_q;
  logic signed [2:0][CoordBits-1:0] v2_q [3];

  function automatic logic signed [CoordBits-1:0] third(logic signed [CoordBits+1:0] s);
    logic [CoordBits+1:0] m;
    logic [2*CoordBits+5:0] p;
    logic [CoordBits+1:0] q;
    m = s[CoordBits+1] ? (CoordBits+2)'(-s) : s;
    m = m + 1'b1;
    // floor(m/3) via reciprocal, with one correction
    p = (2*CoordBits+6)'(m) * (2*CoordBits+6)'((1 << (CoordBits+2)) / 3 + 1);
    q = (CoordBits+2)'(p >> (CoordBits+2));
    if (q * 3 > m) q = q - 1'b1;
    else if (m - q * 3 >= 3) q = q + 1'b1;
    third = s[CoordBits+1] ? CoordBits'(-q) : CoordBits'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    cr_q[0] <= CrossBits'($signed(e1_q[1]) * $signed(e2_q[2]))
               - CrossBits'($signed(e1_q[2]) * $signed(e2_q[1]));
    cr_q[1] <= CrossBits'($signed(e1_q[2]) * $signed(e2_q[0]))
               - CrossBits'($signed(e1_q[0]) * $signed(e2_q[2]));
    cr_q[2] <= CrossBits'($signed(e1_q[0]) * $signed(e2_q[1]))
               - CrossBits'($signed(e1_q[1]) * $signed(e2_q[0]));
    for (int k = 0; k < 3; k++) ct_q[k] <= third(sum_q[k]);
    v2_q <= v_q;
  end

  // stage 3: squares
  logic [2:0][SqBits-1:0] cs_q;
  logic [2:0][2:0][D2Bits-1:0] ds_q;
  logic signed [2:0][CoordBits-1:0] ct3_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic [MagBits-1:0] m;
      m = cr_q[k][CrossBits-1] ? MagBits'(-cr_q[k]) : MagBits'(cr_q[k]);
      cs_q[k] <= SqBits'(m) * SqBits'(m);
      for (int i = 0; i < 3; i++) begin
        logic signed [DistBits-1:0] d;
        logic [DistBits-1:0] a;
        d = DistBits'($signed(v2_q[i][k])) - DistBits'($signed(ct_q[k]));
        a = d[DistBits-1] ? DistBits'(-d) : DistBits'(d);
        ds_q[i][k] <= D2Bits'(a) * D2Bits'(a);
      end
    end
    ct3_q <= ct_q;
  end

  // stage 4: sums
  always_ff @(posedge clk_i) begin
    asq_o <= (cs_q[0] + cs_q[1] + cs_q[2]) >> 2;
    for (int i = 0; i < 3; i++) dsq_o[i] <= ds_q[i][0] + ds_q[i][1] + ds_q[i][2];
    ctr_o <= ct3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0;
    end else begin
      c1_q.vld <= vld_i;
      c1_q.ok <= req_i.indices_valid;
      c1_q.tag <= req_i.triangle_tag;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end
  assign ctl_o = c4_q;
endmodule

>>> sv/triangle_area_and_bounds_core.sv
// Top level of the triangle area and bounds core.
// Depends on tab_pkg, tab_front, tab_isqrt.
//
// channel  | ports                  | handshake
// request  | start_i, req_i, busy_o | taken when start_i and !busy_o
// result   | done_o, res_o          | one-cycle strobe, no backpressure
//
// One request per cycle; 40 register stages from the accepting edge to done_o:
// 4 front stages, 35 square-root stages (one per root bit of the 70-bit area
// square, distance squares in parallel lanes of the same stages), 1 output register.
// busy_o is always low: the result side cannot stall.
// Reset clears the control registers only.
`timescale 1ns / 1ps
`include "triangle_area_and_bounds_core_macros.svh"
module triangle_area_and_bounds_core import tab_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  tab_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output tab_res_t res_o
);
  logic [SqBits-1:0] asq;
  logic [2:0][D2Bits-1:0] dsq;
  logic signed [2:0][CoordBits-1:0] ctr;
  tab_ctl_t fctl, actl;
  logic [SqrtLanes-1:0][SqBits-1:0] sq_in;
  logic [SqrtLanes-1:0][AreaRootBits-1:0] root;
  logic [AreaRootBits-1:0][2:0][CoordBits-1:0] ctr_q;

  assign busy_o = 1'b0;

  tab_front u_front (
    .clk_i, .rst_ni, .vld_i(start_i), .req_i,
    .asq_o(asq), .dsq_o(dsq), .ctr_o(ctr), .ctl_o(fctl)
  );

  always_comb begin
    sq_in[0] = asq;
    for (int l = 0; l < 3; l++) sq_in[l+1] = SqBits'(dsq[l]);
  end

  tab_isqrt u_sqrt (
    .clk_i, .rst_ni, .val_i(sq_in), .ctl_i(fctl), .root_o(root), .ctl_o(actl)
  );

  // centroid rides alongside the root pipeline
  always_ff @(posedge clk_i) begin
    ctr_q[0] <= ctr;
    for (int s = 1; s < AreaRootBits; s++) ctr_q[s] <= ctr_q[s-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= actl.vld;
  end

  always_ff @(posedge clk_i) begin
    logic [AreaRootBits-1:0] r;
    r = root[1];
    if (root[2] > r) r = root[2];
    if (root[3] > r) r = root[3];
    res_o.result_tag <= actl.tag;
    res_o.area <= actl.ok ? AreaBits'(root[0]) : '0;
    res_o.radius <= actl.ok ? RadBits'(r) : '0;
    res_o.center_x <= actl.ok ? ctr_q[AreaRootBits-1][0] : '0;
    res_o.center_y <= actl.ok ? ctr_q[AreaRootBits-1][1] : '0;
    res_o.center_z <= actl.ok ? ctr_q[AreaRootBits-1][2] : '0;
  end

  `TAB_ASSERT(a_busy, clk_i, rst_ni, !busy_o)
  `TAB_ASSERT(a_done, clk_i, rst_ni, done_o == $past(actl.vld))
  `TAB_ASSERT(a_zero, clk_i, rst_ni, !(done_o && !$past(actl.ok)) || res_o.area == '0)
endmodule

>>> dv/triangle_area_and_bounds_core_tb.sv
// Testbench for triangle_area_and_bounds_core: drives triangle requests and
// checks each result against an in-bench predictor through a scoreboard class.
// Depends on tab_pkg and the core RTL.
`timescale 1ns / 1ps
module triangle_area_and_bounds_core_tb;
  import tab_pkg::*;

  localparam int WatchdogLimit = 2000;

  function automatic longint unsigned isqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= x) r = cand;
    end
    return r[63:0];
  endfunction

  function automatic longint third_round(longint s);
    if (s >= 0) return (s + 1) / 3;
    return -((-s + 1) / 3);
  endfunction

  function automatic tab_res_t predict_bounds(tab_req_t q);
    tab_res_t r;
    longint v[3][3];
    longint e1[3], e2[3], cr[3], ctr[3];
    logic [127:0] sum;
    longint unsigned rad, d2, rr;
    longint d;
    v[0][0] = $signed(q.a_x); v[0][1] = $signed(q.a_y); v[0][2] = $signed(q.a_z);
    v[1][0] = $signed(q.b_x); v[1][1] = $signed(q.b_y); v[1][2] = $signed(q.b_z);
    v[2][0] = $signed(q.c_x); v[2][1] = $signed(q.c_y); v[2][2] = $signed(q.c_z);
    r = '0;
    r.result_tag = q.triangle_tag;
    if (q.indices_valid) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] = v[1][k] - v[0][k];
        e2[k] = v[2][k] - v[0][k];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        d = cr[k] < 0 ? -cr[k] : cr[k];
        sum = sum + 128'(d) * 128'(d);
      end
      r.area = AreaBits'(isqrt(sum >> 2));
      for (int k = 0; k < 3; k++) ctr[k] = third_round(v[0][k] + v[1][k] + v[2][k]);
      r.center_x = CoordBits'(ctr[0]);
      r.center_y = CoordBits'(ctr[1]);
      r.center_z = CoordBits'(ctr[2]);
      rad = 0;
      for (int i = 0; i < 3; i++) begin
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          d = v[i][k] - ctr[k];
          d2 += longint'(d * d);
        end
        rr = isqrt(128'(d2));
        if (rr > rad) rad = rr;
      end
      r.radius = RadBits'(rad);
    end
    return r;
  endfunction

  class bounds_scoreboard;
    tab_res_t pending[$];
    int errors;
    int checked;

    function void note_request(tab_req_t q);
      pending.push_back(predict_bounds(q));
    endfunction

    function void check_result(tab_res_t got);
      tab_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.area !== want.area) begin
        $display("%0t: area exp %0d got %0d", $time, want.area, got.area); errors++;
      end
      if (got.center_x !== want.center_x) begin
        $display("%0t: center_x exp %h got %h", $time, want.center_x, got.center_x);
        errors++;
      end
      if (got.center_y !== want.center_y) begin
        $display("%0t: center_y exp %h got %h", $time, want.center_y, got.center_y);
        errors++;
      end
      if (got.center_z !== want.center_z) begin
        $display("%0t: center_z exp %h got %h", $time, want.center_z, got.center_z);
        errors++;
      end
      if (got.radius !== want.radius) begin
        $display("%0t: radius exp %0d got %0d", $time, want.radius, got.radius); errors++;
      end
      if (got.result_tag !== want.result_tag) begin
        $display("%0t: tag exp %h got %h", $time, want.result_tag, got.result_tag);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  tab_req_t req_i = '0;
  logic busy_o, done_o;
  tab_res_t res_o;
  int idle_pct = 12;
  int quiet_cycles = 0;
  int sent = 0;
  int valid_seen = 0;
  bounds_scoreboard sb = new();

  triangle_area_and_bounds_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(req_i);
      if (done_o) sb.check_result(res_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(tab_req_t q);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
    if (q.indices_valid) valid_seen++;
  endtask

  task automatic send_corner(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic ok);
    tab_req_t q;
    q = '{a_x: a, a_y: a, a_z: b, b_x: b, b_y: c, b_z: a, c_x: c, c_y: b, c_z: c,
          indices_valid: ok, triangle_tag: 16'($urandom)};
    send_request(q);
  endtask

  task automatic send_random(int n);
    tab_req_t q;
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      q.a_x = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.a_y = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.a_z = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.b_x = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.b_y = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.b_z = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.c_x = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.c_y = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      q.c_z = rand_coord(mode < 1 ? $urandom_range(0, 1) : (mode < 4 ? 2 : 3));
      if (mode == 9) begin
        // degenerate: C coincident with B
        q.c_x = q.b_x; q.c_y = q.b_y; q.c_z = q.b_z;
      end
      q.indices_valid = ($urandom_range(0, 9) != 0);
      q.triangle_tag = 16'($urandom);
      send_request(q);
    end
  endtask

  initial begin
    int drain;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_corner(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_corner(16'h8000, 16'h7fff, 16'h8000, 1'b1);
    send_corner(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_corner(16'h8000, 16'h8000, 16'h7fff, 1'b1);
    send_corner(16'h7fff, 16'h7fff, 16'h8000, 1'b1);
    send_corner(16'hffff, 16'h0001, 16'h0010, 1'b1);
    send_corner(16'h0010, 16'h0010, 16'h0010, 1'b1);
    send_corner(16'h8000, 16'h7fff, 16'h0000, 1'b0);
    send_corner(16'h1234, 16'hfedc, 16'h0f0f, 1'b0);
    send_corner(16'hffff, 16'hfffe, 16'h0002, 1'b1);
    send_random(380);
    idle_pct = 57;
    send_random(380);
    idle_pct = 0;
    send_random(380);
    start_i <= 1'b0;
    drain = 0;
    while (sb.pending.size() != 0 && drain < WatchdogLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (50) @(posedge clk_i);
    $display("Sent %0d triangles (%0d valid), checked %0d results across three idle mixes",
             sent, valid_seen, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
